>>> rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a fixed message, disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Clocked assertion with a caller-supplied message string.
`define ASSERT_CLK_MSG(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

`endif

>>> rtl/core/pidc_pkg.sv
`default_nettype none
package pidc_pkg;

	localparam int Q_W    = 32;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;

	// Stages an item can occupy: five pipeline stages plus the output register.
	localparam int PIPE_DEPTH = 6;

	localparam logic [30:0] LIMIT_RESET = 31'h7FFF_FFFF;

	typedef enum logic [2:0] {
		REG_PROP_GAIN    = 3'd0,
		REG_INTEG_GAIN   = 3'd1,
		REG_DERIV_GAIN   = 3'd2,
		REG_OUTPUT_LIMIT = 3'd3,
		REG_WINDUP_LIMIT = 3'd4
	} reg_idx_t;

endpackage
`default_nettype wire

>>> rtl/core/pidc_sample_if.sv
`default_nettype none
interface pidc_sample_if
	import pidc_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic signed [Q_W-1:0] setpoint;
	logic signed [Q_W-1:0] measurement;

	modport source (output valid, output setpoint, output measurement, input ready);
	modport sink   (input valid, input setpoint, input measurement, output ready);
endinterface
`default_nettype wire

>>> rtl/core/pidc_command_if.sv
`default_nettype none
interface pidc_command_if
	import pidc_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic signed [Q_W-1:0] control_signal;
	logic                  output_clamped;

	modport source (output valid, output control_signal, output output_clamped, input ready);
	modport sink   (input valid, input control_signal, input output_clamped, output ready);
endinterface
`default_nettype wire

>>> rtl/core/pid_controller_clamped.sv
// An item is registered in each pipeline stage and then in the output register.
// Throughput: one item per cycle while the command side keeps taking results.
// Each stage moves on when it is empty or its successor moves, so bubbles fill
// while a finished result waits at the output register.
// Reset (arst_n low, asynchronous): pipeline empty, error sum and last error
// zero, gains zero, both limits at full scale.
`default_nettype none
module pid_controller_clamped
	import pidc_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int SUM_BITS  = 48
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   psel,
	input  wire                   penable,
	input  wire                   pwrite,
	input  wire  [ADDR_W-1:0]     paddr,
	input  wire  [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready,
	pidc_sample_if.sink           sample,
	pidc_command_if.source        command
);

	// Width of the exact P+I+D total: |P| < 2^(64-F), |D| < 2^(65-F), |I| < 2^31.
	localparam int TOT_W = 67 - FRAC_BITS;
	localparam int P_W   = 64 - FRAC_BITS;
	localparam int D_W   = 65 - FRAC_BITS;
	localparam int IF_W  = SUM_BITS + 32;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic signed [31:0] kp_q;
	logic signed [31:0] ki_q;
	logic signed [31:0] kd_q;
	logic [30:0]        out_lim_q;
	logic [30:0]        wind_lim_q;
	reg_idx_t           reg_idx;

	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q       <= '0;
			ki_q       <= '0;
			kd_q       <= '0;
			out_lim_q  <= LIMIT_RESET;
			wind_lim_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_PROP_GAIN:    kp_q       <= pwdata;
				REG_INTEG_GAIN:   ki_q       <= pwdata;
				REG_DERIV_GAIN:   kd_q       <= pwdata;
				REG_OUTPUT_LIMIT: out_lim_q  <= pwdata[30:0];
				REG_WINDUP_LIMIT: wind_lim_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PROP_GAIN:    prdata = kp_q;
			REG_INTEG_GAIN:   prdata = ki_q;
			REG_DERIV_GAIN:   prdata = kd_q;
			REG_OUTPUT_LIMIT: prdata = {1'b0, out_lim_q};
			REG_WINDUP_LIMIT: prdata = {1'b0, wind_lim_q};
			default:          prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Stage handshake: a stage loads when empty or when it hands off
	// ---------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_v_q;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_out;

	assign ld_out = !out_v_q || command.ready;
	assign ld_s5  = !v_s5 || ld_out;
	assign ld_s4  = !v_s4 || ld_s5;
	assign ld_s3  = !v_s3 || ld_s4;
	assign ld_s2  = !v_s2 || ld_s3;
	assign ld_s1  = !v_s1 || ld_s2;

	assign sample.ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (ld_s1)  v_s1    <= sample.valid;
			if (ld_s2)  v_s2    <= v_s1;
			if (ld_s3)  v_s3    <= v_s2;
			if (ld_s4)  v_s4    <= v_s3;
			if (ld_s5)  v_s5    <= v_s4;
			if (ld_out) out_v_q <= v_s5;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: input register
	// ---------------------------------------------------------------
	logic signed [31:0] sp_s1, ms_s1;

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			sp_s1 <= sample.setpoint;
			ms_s1 <= sample.measurement;
		end
	end

	// Saturating error, saturating error sum, derivative difference.
	logic [32:0]          err_wide;
	logic signed [31:0]   err;
	logic [SUM_BITS:0]    sum_wide;
	logic [SUM_BITS-1:0]  sum_new;
	logic [32:0]          dd_new;
	logic                 d_en;

	assign err_wide = {sp_s1[31], sp_s1} - {ms_s1[31], ms_s1};

	always_comb begin
		if (err_wide[32] != err_wide[31])
			err = err_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			err = err_wide[31:0];
	end

	logic signed [SUM_BITS-1:0] error_sum_q;
	logic signed [31:0]         prev_err_q;

	assign sum_wide = {error_sum_q[SUM_BITS-1], error_sum_q}
		+ {{(SUM_BITS-31){err[31]}}, err};

	always_comb begin
		if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1])
			sum_new = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
				: {1'b0, {(SUM_BITS-1){1'b1}}};
		else
			sum_new = sum_wide[SUM_BITS-1:0];
	end

	assign dd_new = {err[31], err} - {prev_err_q[31], prev_err_q};
	assign d_en   = (kd_q != '0);

	// Advance the accumulator only when an item leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
			prev_err_q  <= '0;
		end else if (v_s1 && ld_s2) begin
			error_sum_q <= sum_new;
			if (d_en)
				prev_err_q <= err;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: error, updated sum, derivative difference
	// ---------------------------------------------------------------
	logic signed [31:0]   err_s2;
	logic [SUM_BITS-1:0]  sum_s2;
	logic [32:0]          dd_s2;
	logic                 den_s2;

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			err_s2 <= err;
			sum_s2 <= sum_new;
			dd_s2  <= dd_new;
			den_s2 <= d_en;
		end
	end

	// Magnitudes; the products are taken on magnitudes and truncate toward zero.
	logic [31:0]          err_mag, kp_mag, ki_mag, kd_mag;
	logic [32:0]          dd_mag;
	logic [SUM_BITS-1:0]  sum_mag;

	assign err_mag = err_s2[31] ? (~err_s2 + 32'd1) : err_s2;
	assign kp_mag  = kp_q[31] ? (~kp_q + 32'd1) : kp_q;
	assign ki_mag  = ki_q[31] ? (~ki_q + 32'd1) : ki_q;
	assign kd_mag  = kd_q[31] ? (~kd_q + 32'd1) : kd_q;
	assign dd_mag  = dd_s2[32] ? (~dd_s2 + 33'd1) : dd_s2;
	assign sum_mag = sum_s2[SUM_BITS-1] ? (~sum_s2 + SUM_BITS'(1)) : sum_s2;

	// ---------------------------------------------------------------
	// Stage 3: partial products; the integral sum is split at bit 32, not in equal halves
	// ---------------------------------------------------------------
	logic [63:0]        p_pp_s3;
	logic [64:0]        d_pp_s3;
	logic [63:0]        i_lo_s3;
	logic [SUM_BITS-1:0] i_hi_s3;
	logic               p_neg_s3, d_neg_s3, i_neg_s3, den_s3;

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			p_pp_s3  <= 64'(err_mag) * 64'(kp_mag);
			d_pp_s3  <= 65'(dd_mag) * 65'(kd_mag);
			i_lo_s3  <= 64'(sum_mag[31:0]) * 64'(ki_mag);
			i_hi_s3  <= SUM_BITS'(sum_mag[SUM_BITS-1:32]) * SUM_BITS'(ki_mag);
			p_neg_s3 <= err_s2[31] ^ kp_q[31];
			d_neg_s3 <= dd_s2[32] ^ kd_q[31];
			i_neg_s3 <= sum_s2[SUM_BITS-1] ^ ki_q[31];
			den_s3   <= den_s2;
		end
	end

	// Recombine, shift, apply the windup limit and the signs; zero the derivative when off.
	logic [IF_W-1:0]          i_full, i_sh;
	logic [30:0]              i_mag;
	logic signed [31:0]       i_val;
	logic [TOT_W-1:0]         p_ext, d_ext;
	logic signed [TOT_W-1:0]  p_val, d_val;

	assign i_full = {i_hi_s3, 32'd0} + IF_W'(i_lo_s3);
	assign i_sh   = i_full >> FRAC_BITS;
	assign i_mag  = (i_sh > IF_W'(wind_lim_q)) ? wind_lim_q : i_sh[30:0];
	assign i_val  = i_neg_s3 ? -$signed({1'b0, i_mag}) : $signed({1'b0, i_mag});

	assign p_ext = {{(TOT_W-P_W){1'b0}}, p_pp_s3[63:FRAC_BITS]};
	assign d_ext = {{(TOT_W-D_W){1'b0}}, d_pp_s3[64:FRAC_BITS]};
	assign p_val = p_neg_s3 ? -$signed(p_ext) : $signed(p_ext);

	always_comb begin
		if (!den_s3)
			d_val = '0;
		else
			d_val = d_neg_s3 ? -$signed(d_ext) : $signed(d_ext);
	end

	// ---------------------------------------------------------------
	// Stage 4: signed terms
	// ---------------------------------------------------------------
	logic signed [TOT_W-1:0] p_s4, d_s4;
	logic signed [31:0]      i_s4;

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			p_s4 <= p_val;
			d_s4 <= d_val;
			i_s4 <= i_val;
		end
	end

	// ---------------------------------------------------------------
	// Stage 5: exact total, no wrap
	// ---------------------------------------------------------------
	logic signed [TOT_W-1:0] tot_s5;

	always_ff @(posedge clk) begin
		if (ld_s5)
			tot_s5 <= p_s4 + d_s4 + TOT_W'(i_s4);
	end

	// Output clamp to the symmetric limit.
	logic signed [TOT_W-1:0] lim_pos, lim_neg;
	logic signed [31:0]      ctl_next;
	logic                    hit_next;

	assign lim_pos = $signed({{(TOT_W-31){1'b0}}, out_lim_q});
	assign lim_neg = -lim_pos;

	always_comb begin
		if (tot_s5 > lim_pos) begin
			ctl_next = lim_pos[31:0];
			hit_next = 1'b1;
		end else if (tot_s5 < lim_neg) begin
			ctl_next = lim_neg[31:0];
			hit_next = 1'b1;
		end else begin
			ctl_next = tot_s5[31:0];
			hit_next = 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Output register: hold the result until the sink takes it
	// ---------------------------------------------------------------
	logic signed [31:0] ctl_q;
	logic               clamp_q;

	always_ff @(posedge clk) begin
		if (ld_out) begin
			ctl_q   <= ctl_next;
			clamp_q <= hit_next;
		end
	end

	assign command.valid          = out_v_q;
	assign command.control_signal = ctl_q;
	assign command.output_clamped = clamp_q;

endmodule
`default_nettype wire

>>> rtl/core/pidc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module pidc_checker
	import pidc_pkg::*;
(
	input wire                  clk,
	input wire                  arst_n,
	input wire                  sample_valid,
	input wire                  sample_ready,
	input wire                  command_valid,
	input wire                  command_ready,
	input wire signed [Q_W-1:0] control_signal,
	input wire                  output_clamped
);

	localparam logic [2:0] DEPTH = 3'(PIPE_DEPTH);

	logic       in_acc, out_acc;
	logic [2:0] cnt_q;

	assign in_acc  = sample_valid && sample_ready;
	assign out_acc = command_valid && command_ready;

	// Track items in flight between the two channels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	`ASSERT_CLK(a_stall_hold, clk, arst_n, command_valid && !command_ready |=> command_valid && $stable(control_signal) && $stable(output_clamped))
	`ASSERT_CLK_MSG(a_no_min_code, clk, arst_n, command_valid |-> control_signal != 32'sh8000_0000, "result outside symmetric limit")
	`ASSERT_CLK_MSG(a_empty_ready, clk, arst_n, !command_valid |-> sample_ready, "input stalled with empty output")
	`ASSERT_CLK_MSG(a_no_invented, clk, arst_n, cnt_q == 3'd0 |-> !command_valid, "result with no item in flight")
	`ASSERT_CLK_MSG(a_depth_bound, clk, arst_n, cnt_q <= DEPTH, "more items in flight than stages")

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.sample_valid   (sample.valid),
	.sample_ready   (sample.ready),
	.command_valid  (command.valid),
	.command_ready  (command.ready),
	.control_signal (command.control_signal),
	.output_clamped (command.output_clamped)
);
`default_nettype wire

>>> test/tb_pid_controller_clamped.sv
`timescale 1ns / 1ps
module tb_pid_controller_clamped;
	import pidc_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int SUM_BITS  = 48;

	// Register map: five registers at word addresses, anything above is unmapped.
	localparam int REG_COUNT = 5;
	localparam int UNMAPPED_LAST = 7;

	// Random part: a fresh register setting for every block of items.
	localparam int RAND_BLOCKS = 12;
	localparam int BLOCK_ITEMS = 150;
	localparam int TAIL_ITEMS  = 20;

	localparam int CYCLE_LIMIT = 50_000;

	localparam logic [Q_W-1:0] Q_POS_FULL = 32'h7FFF_FFFF;
	localparam logic [Q_W-1:0] Q_NEG_FULL = 32'h8000_0000;
	localparam logic [Q_W-1:0] Q_ONE      = 32'h0001_0000;
	localparam logic [Q_W-1:0] Q_HALF     = 32'h0000_8000;
	localparam logic [Q_W-1:0] Q_LSB      = 32'h0000_0001;
	localparam logic [Q_W-1:0] Q_ZERO     = 32'h0000_0000;

	localparam longint ERR_MAX = 64'sd2147483647;
	localparam longint ERR_MIN = -ERR_MAX - 1;
	localparam longint SUM_MAX = (longint'(1) << (SUM_BITS - 1)) - 1;
	localparam longint SUM_MIN = -SUM_MAX - 1;
	localparam logic [127:0] MUL_CAP = 128'd1 << 62;

	typedef struct packed {
		logic [Q_W-1:0] control;
		logic           clamped;
	} command_t;

	// Shadow of the controller: gains, limits, error sum and last error, plus
	// the commands still owed by the block in acceptance order.
	class pid_tracker;
		longint kp, ki, kd, out_lim, wind_lim;
		longint err_sum, last_err;
		command_t due_commands[$];
		int mismatches;
		int checked;

		function new();
			kp = 0;
			ki = 0;
			kd = 0;
			out_lim = longint'(LIMIT_RESET);
			wind_lim = longint'(LIMIT_RESET);
			err_sum = 0;
			last_err = 0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
			case (idx)
				REG_PROP_GAIN:    kp = longint'(signed'(value));
				REG_INTEG_GAIN:   ki = longint'(signed'(value));
				REG_DERIV_GAIN:   kd = longint'(signed'(value));
				REG_OUTPUT_LIMIT: out_lim = longint'(value[30:0]);
				REG_WINDUP_LIMIT: wind_lim = longint'(value[30:0]);
				default: ;
			endcase
		endfunction

		// Exact product, magnitude shifted down by FRAC_BITS, saturated at 2^62.
		function longint fixed_mul(longint a, longint b);
			logic [63:0] abs_a, abs_b;
			logic [127:0] prod;
			logic neg;
			neg = (a < 0) != (b < 0);
			abs_a = (a < 0) ? -a : a;
			abs_b = (b < 0) ? -b : b;
			prod = ({64'd0, abs_a} * {64'd0, abs_b}) >> FRAC_BITS;
			if (prod > MUL_CAP)
				prod = MUL_CAP;
			return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
		endfunction

		function longint clamp_sym(longint v, longint lim, output logic hit);
			hit = 1'b0;
			if (v > lim) begin
				hit = 1'b1;
				return lim;
			end
			if (v < -lim) begin
				hit = 1'b1;
				return -lim;
			end
			return v;
		endfunction

		function void accept_sample(logic signed [Q_W-1:0] sp, logic signed [Q_W-1:0] ms);
			longint err, prop, integ, deriv, total;
			logic windup_hit, out_hit;
			command_t due;
			err = longint'(sp) - longint'(ms);
			if (err > ERR_MAX)
				err = ERR_MAX;
			else if (err < ERR_MIN)
				err = ERR_MIN;

			if (err > 0 && err_sum > SUM_MAX - err)
				err_sum = SUM_MAX;
			else if (err < 0 && err_sum < SUM_MIN - err)
				err_sum = SUM_MIN;
			else
				err_sum += err;

			prop = fixed_mul(err, kp);
			integ = clamp_sym(fixed_mul(err_sum, ki), wind_lim, windup_hit);
			deriv = 0;
			if (kd != 0) begin
				deriv = fixed_mul(err - last_err, kd);
				last_err = err;
			end
			total = clamp_sym(prop + integ + deriv, out_lim, out_hit);

			due.control = total[Q_W-1:0];
			due.clamped = out_hit;
			due_commands.push_back(due);
		endfunction

		function void report(string what, logic [Q_W-1:0] want, logic [Q_W-1:0] got);
			mismatches++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
		endfunction

		function void check_command(logic [Q_W-1:0] control, logic clamped);
			command_t want;
			if (due_commands.size() == 0) begin
				mismatches++;
				$display("%0t: command %h/%b arrived, expected none", $time,
					control, clamped);
				return;
			end
			want = due_commands.pop_front();
			checked++;
			if (control !== want.control)
				report("control_signal", want.control, control);
			if (clamped !== want.clamped)
				report("output_clamped", Q_W'(want.clamped), Q_W'(clamped));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	pidc_sample_if  sample_ch();
	pidc_command_if command_ch();

	pid_tracker tracker;
	int send_idle_pct;
	int recv_idle_pct;
	int settings_count;
	int cycle_count = 0;

	pid_controller_clamped #(
		.FRAC_BITS(FRAC_BITS),
		.SUM_BITS(SUM_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample(sample_ch),
		.command(command_ch)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Stall the command side at random; the percentage changes per phase.
	always @(posedge clk) begin
		command_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Sample both channels at the edge. Everything is driven with nonblocking
	// assignments, so the values seen here are the ones the edge acts on.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready)
				tracker.accept_sample(sample_ch.setpoint, sample_ch.measurement);
			if (command_ch.valid && command_ch.ready)
				tracker.check_command(command_ch.control_signal, command_ch.output_clamped);
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d commands outstanding", cycle_count,
				tracker.due_commands.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Two-phase register write: setup, then access until pready. Return to idle with
	// psel low before the task ends, so back-to-back writes never reassign psel in one step.
	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		apb_write(ADDR_W'(4 * int'(idx)), value);
		tracker.write_reg(idx, value);
	endtask

	// Drop valid and hold until every owed command has come back. The first
	// edge lets the monitor record an item accepted at the caller's edge.
	task automatic wait_for_commands();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.due_commands.size() != 0)
			@(posedge clk);
	endtask

	// Registers change only with the pipeline empty.
	task automatic apply_settings(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
			input logic [DATA_W-1:0] kd, input logic [DATA_W-1:0] out_lim,
			input logic [DATA_W-1:0] wind_lim);
		wait_for_commands();
		set_reg(REG_PROP_GAIN, kp);
		set_reg(REG_INTEG_GAIN, ki);
		set_reg(REG_DERIV_GAIN, kd);
		set_reg(REG_OUTPUT_LIMIT, out_lim);
		set_reg(REG_WINDUP_LIMIT, wind_lim);
		settings_count++;
	endtask

	// Present one item after a random gap and hold it until accepted.
	task automatic send_sample(input logic [Q_W-1:0] sp, input logic [Q_W-1:0] ms);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.setpoint <= sp;
		sample_ch.measurement <= ms;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
	endtask

	task automatic set_idling(input int phase);
		case (phase)
			0: begin
				send_idle_pct = 37;
				recv_idle_pct = 59;
			end
			1: begin
				send_idle_pct = 59;
				recv_idle_pct = 37;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// Mostly values within +/-8.0, with the rails and full-width noise mixed in.
	function automatic logic [Q_W-1:0] pick_q16();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(9))
			0: return Q_POS_FULL;
			1: return Q_NEG_FULL;
			2, 3: return r;
			default: return {{12{r[19]}}, r[19:0]};
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_gain();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(7))
			0: return Q_ZERO;
			1: return Q_POS_FULL;
			2: return Q_NEG_FULL;
			3: return r;
			default: return {{13{r[18]}}, r[18:0]};
		endcase
	endfunction

	// Full-width noise sets bit 31 too, which the 31-bit limits must drop.
	function automatic logic [DATA_W-1:0] pick_limit();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(5))
			0: return Q_ZERO;
			1: return Q_POS_FULL;
			2: return r;
			default: return {7'd0, r[24:0]};
		endcase
	endfunction

	initial begin
		int blk, n, kind;
		logic [Q_W-1:0] sp, ms;
		logic [31:0] r;

		tracker = new();
		settings_count = 0;
		set_idling(2);
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.setpoint = '0;
		sample_ch.measurement = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(0);

		// Reset values: all gains zero, so both full-scale errors give zero out,
		// but the error saturates both ways and the sum still accumulates.
		send_sample(Q_POS_FULL, Q_NEG_FULL);
		send_sample(Q_NEG_FULL, Q_POS_FULL);

		// Unity gains on every path, limits wide open.
		apply_settings(Q_ONE, Q_ONE, Q_ONE, Q_POS_FULL, Q_POS_FULL);
		send_sample(Q_ZERO, Q_ZERO);
		send_sample(Q_ONE, Q_ZERO);
		send_sample(Q_POS_FULL, Q_ZERO);
		send_sample(Q_NEG_FULL, Q_ZERO);
		send_sample(Q_ZERO, Q_NEG_FULL);
		send_sample(Q_NEG_FULL, Q_LSB);
		send_sample(Q_HALF, -Q_HALF);

		// Zero limits: integral and output forced to zero, flag set whenever the
		// raw total is nonzero. Unmapped writes in between must change nothing.
		apply_settings(Q_POS_FULL, Q_NEG_FULL, Q_NEG_FULL, Q_ZERO, Q_ZERO);
		apb_write(ADDR_W'(4 * REG_COUNT), $urandom);
		apb_write(ADDR_W'(4 * UNMAPPED_LAST), $urandom);
		send_sample(Q_ONE, Q_ZERO);
		send_sample(Q_ZERO, Q_ZERO);
		send_sample(Q_ZERO, Q_ZERO);

		// Derivative off: the last error must be held, not updated.
		apply_settings(Q_NEG_FULL, Q_POS_FULL, Q_ZERO, Q_ONE << 1, Q_ONE);
		send_sample(Q_ONE, Q_ZERO);
		send_sample(Q_NEG_FULL, Q_POS_FULL);
		send_sample(Q_ZERO, Q_ONE);
		send_sample(Q_HALF, Q_ZERO);

		// Derivative back on: the first difference uses the held last error.
		apply_settings(Q_ZERO, Q_ZERO, Q_HALF, Q_POS_FULL, Q_POS_FULL);
		send_sample(Q_ONE, Q_ONE);
		send_sample(Q_POS_FULL, Q_ZERO);

		// Random part: three idling mixes, a new register setting per block.
		// Most items keep the measurement near the setpoint, as a loop in
		// operation would, so the error sum wanders instead of railing at once.
		for (blk = 0; blk < RAND_BLOCKS; blk++) begin
			set_idling(blk / (RAND_BLOCKS / 3));
			apply_settings(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
			for (n = 0; n < BLOCK_ITEMS; n++) begin
				kind = $urandom_range(9);
				sp = pick_q16();
				if (kind < 6) begin
					r = $urandom;
					ms = sp + {{16{r[15]}}, r[15:0]};
				end else begin
					ms = pick_q16();
				end
				send_sample(sp, ms);
			end
		end

		// Full-scale integral gain on whatever sum the random part left behind.
		apply_settings(pick_gain(), Q_POS_FULL, pick_gain(), pick_limit(), pick_limit());
		for (n = 0; n < TAIL_ITEMS; n++)
			send_sample(pick_q16(), pick_q16());

		// Drain, then give any stray command time to show up.
		wait_for_commands();
		repeat (2 * PIPE_DEPTH) @(posedge clk);

		$display("Run covered %0d commands over %0d register settings and three idling mixes,",
			tracker.checked, settings_count);
		$display("with zero limits, unmapped writes and the derivative path off and back on.");
		if (tracker.mismatches == 0 && tracker.due_commands.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/pidc_pkg.sv
rtl/core/pidc_sample_if.sv
rtl/core/pidc_command_if.sv
rtl/core/pid_controller_clamped.sv
rtl/core/pidc_checker.sv
test/tb_pid_controller_clamped.sv
